/* sv/gbs_pkg.sv */
package gbs_pkg;

    localparam int BOX_W       = 16;
    localparam int SIZE_W      = 15;
    localparam int AREA_W      = 30;
    localparam int THR_W       = 16;
    localparam int IDX_W       = 10;
    localparam int COUNT_OUT_W = 7;
    localparam int UNION_W     = AREA_W + 1;
    localparam int PROD_W      = THR_W + UNION_W;

    localparam int MAX_KEPT_DEFAULT = 64;

    localparam logic [IDX_W-1:0] POS_MAX   = 10'd1023;
    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic signed [BOX_W-1:0] left;
        logic signed [BOX_W-1:0] top;
        logic [SIZE_W-1:0]       width;
        logic [SIZE_W-1:0]       height;
    } box_t;

    typedef struct packed {
        box_t              box;
        logic [AREA_W-1:0] area;
    } kept_entry_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } iou_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } gbs_state_t;

endpackage

/* sv/gbs_store.sv */
module gbs_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  gbs_pkg::kept_entry_t  wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output gbs_pkg::kept_entry_t  rd_data
);
    import gbs_pkg::*;

    kept_entry_t mem [DEPTH];
    kept_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/gbs_iou.sv */
module gbs_iou (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req,
    input  gbs_pkg::box_t                box,
    input  logic [gbs_pkg::AREA_W-1:0]   area,
    input  logic [gbs_pkg::THR_W-1:0]    thr,
    input  gbs_pkg::kept_entry_t         rd_data,
    output gbs_pkg::iou_status_t         status
);
    import gbs_pkg::*;

    // stage valids: 1 data out of memory, 2 overlap widths, 3 intersection,
    // 4 union, 5 scaled threshold product
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic [SIZE_W-1:0]   iw_reg, ih_reg;
    logic [AREA_W-1:0]   karea2_reg, karea3_reg;
    logic [AREA_W-1:0]   inter3_reg, inter4_reg, inter5_reg;
    logic [UNION_W-1:0]  union4_reg;
    logic [PROD_W-1:0]   prod5_reg;

    logic signed [BOX_W:0] a0x, b0x, aex, bex, lox, hix, dx;
    logic signed [BOX_W:0] a0y, b0y, aey, bey, loy, hiy, dy;
    logic [SIZE_W-1:0]     iw, ih;
    logic [PROD_W-1:0]     inter_scaled;

    always_comb
    begin
        a0x = signed'({box.left[BOX_W-1], box.left});
        b0x = signed'({rd_data.box.left[BOX_W-1], rd_data.box.left});
        aex = a0x + signed'({2'b00, box.width});
        bex = b0x + signed'({2'b00, rd_data.box.width});
        lox = (a0x > b0x) ? a0x : b0x;
        hix = (aex < bex) ? aex : bex;
        dx  = hix - lox;
        iw  = (hix > lox) ? dx[SIZE_W-1:0] : '0;

        a0y = signed'({box.top[BOX_W-1], box.top});
        b0y = signed'({rd_data.box.top[BOX_W-1], rd_data.box.top});
        aey = a0y + signed'({2'b00, box.height});
        bey = b0y + signed'({2'b00, rd_data.box.height});
        loy = (a0y > b0y) ? a0y : b0y;
        hiy = (aey < bey) ? aey : bey;
        dy  = hiy - loy;
        ih  = (hiy > loy) ? dy[SIZE_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        iw_reg     <= iw;
        ih_reg     <= ih;
        karea2_reg <= rd_data.area;
        inter3_reg <= AREA_W'(iw_reg * ih_reg);
        karea3_reg <= karea2_reg;
        union4_reg <= UNION_W'({1'b0, area} + {1'b0, karea3_reg} - {1'b0, inter3_reg});
        inter4_reg <= inter3_reg;
        prod5_reg  <= PROD_W'(thr * union4_reg);
        inter5_reg <= inter4_reg;
    end

    assign inter_scaled = PROD_W'({inter5_reg, 16'h0000});

    assign status.busy = req | v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign status.hit  = v5_reg && (inter_scaled > prod5_reg);

endmodule

/* sv/greedy_box_suppression.sv */
// greedy box suppression by intersection over union
// boxes enter on the input channel (in_valid / in_stall) already sorted by
// falling score; first_box starts a new set and empties the kept list
// each input transaction yields exactly one result transaction on the output
// channel (out_valid / out_stall) carrying keep, box_index, kept_count and
// overflow
// the kept list lives in a single-port-read memory; every box is compared
// against each stored box, one memory read per cycle, through a five stage
// overlap / multiply / compare pipeline
// the result waits for every stored box to be read through the one read
// port of the kept store and to pass the five stage compare pipeline
// in_stall is high while a box is being scanned; the next box is accepted
// as soon as the previous result sits in the output register
// if the receiver holds out_stall, the finished result waits in the output
// register and the block holds its next result until the slot frees
// iou_threshold is written through the cfg channel; the user must write it
// only while the block is idle, which the block itself does not enforce
// reset empties the kept list, restarts the box position at zero and loads
// the default threshold; memory contents are not cleared
module greedy_box_suppression #(
    parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gbs_pkg::THR_W-1:0]         iou_threshold,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              first_box,
    input  logic signed [gbs_pkg::BOX_W-1:0]  box_left,
    input  logic signed [gbs_pkg::BOX_W-1:0]  box_top,
    input  logic [gbs_pkg::SIZE_W-1:0]        box_width,
    input  logic [gbs_pkg::SIZE_W-1:0]        box_height,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              keep,
    output logic [gbs_pkg::IDX_W-1:0]         box_index,
    output logic [gbs_pkg::COUNT_OUT_W-1:0]   kept_count,
    output logic                              overflow
);
    import gbs_pkg::*;

    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam logic [CW-1:0] FULL = CW'(MAX_KEPT);

    gbs_state_t state_reg, state_next;

    logic [THR_W-1:0]   thr_reg;
    logic [CW-1:0]      total_reg, total_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [CW-1:0]      rd_idx_reg;
    logic               suppress_reg;

    box_t               box_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic               out_valid_reg;
    logic               keep_reg;
    logic [IDX_W-1:0]   box_index_reg;
    logic [CW-1:0]      count_reg;
    logic               overflow_reg;

    // control decoded from state
    logic               accept;
    logic               rd_en;
    logic               slot_free;
    logic               finish;
    logic               store_wr;

    kept_entry_t        wr_entry;
    kept_entry_t        rd_entry;
    iou_status_t        iou_status;

    logic [CW-1:0]      total_eff;
    logic [IDX_W-1:0]   pos_eff;

    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_idx_reg >= total_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!iou_status.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall = 1'b1;
        rd_en    = 1'b0;
        finish   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SCAN:
            begin
                rd_en = (rd_idx_reg < total_reg);
            end
            ST_DRAIN:
            begin
                rd_en = 1'b0;
            end
            ST_DONE:
            begin
                finish = slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept   = in_valid && !in_stall;
    assign store_wr = finish && !suppress_reg && (total_reg < FULL);

    // a first box restarts the set before it is processed
    assign total_eff = first_box ? '0 : total_reg;
    assign pos_eff   = first_box ? '0 : pos_reg;

    always_comb
    begin
        total_next = total_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            total_next = total_eff;
            pos_next   = (pos_eff < POS_MAX) ? pos_eff + 1'b1 : pos_eff;
        end
        else if (store_wr)
        begin
            total_next = total_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= THR_RESET;
            total_reg     <= '0;
            pos_reg       <= '0;
            rd_idx_reg    <= '0;
            suppress_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            pos_reg   <= pos_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= iou_threshold;
            end
            if (accept)
            begin
                rd_idx_reg   <= '0;
                suppress_reg <= 1'b0;
            end
            else
            begin
                if (rd_en)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (iou_status.hit)
                begin
                    suppress_reg <= 1'b1;
                end
            end
            // result slot: load on finish, free on downstream transaction
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            box_reg.left   <= box_left;
            box_reg.top    <= box_top;
            box_reg.width  <= box_width;
            box_reg.height <= box_height;
            area_reg       <= AREA_W'(box_width * box_height);
            idx_reg        <= pos_eff;
        end
        if (finish)
        begin
            keep_reg      <= !suppress_reg;
            box_index_reg <= idx_reg;
            count_reg     <= store_wr ? total_reg + 1'b1 : total_reg;
            overflow_reg  <= !suppress_reg && (total_reg >= FULL);
        end
    end

    assign wr_entry.box  = box_reg;
    assign wr_entry.area = area_reg;

    gbs_store #(
        .DEPTH (MAX_KEPT),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (total_reg[AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_entry)
    );

    gbs_iou u_iou (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (rd_en),
        .box     (box_reg),
        .area    (area_reg),
        .thr     (thr_reg),
        .rd_data (rd_entry),
        .status  (iou_status)
    );

    assign out_valid  = out_valid_reg;
    assign keep       = keep_reg;
    assign box_index  = box_index_reg;
    assign kept_count = COUNT_OUT_W'(count_reg);
    assign overflow   = overflow_reg;

`ifndef SYNTHESIS
    // a box is never both dropped and flagged as overflow
    a_ovf_needs_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(overflow && !keep))
        else $error("overflow raised on a suppressed box");

    // the kept list never grows past the store depth
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= FULL)
        else $error("kept count beyond store depth");

    // an accepted box always starts a scan of the store
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN) && (rd_idx_reg == '0))
        else $error("accepted box did not start a scan");

    // the store is written only when a result is loaded
    a_write_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr |=> out_valid_reg && keep_reg && !overflow_reg)
        else $error("store write without a kept result");
`endif

endmodule

/* test/tb.sv */
module tb;
    import gbs_pkg::*;

    // store depth of the instance under test and run bounds
    localparam int N_KEPT      = MAX_KEPT_DEFAULT;
    localparam int DRAIN_WAIT  = N_KEPT + 24;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_LEN    = 400;
    localparam int HOLD_AT     = 120;
    localparam int IDLE_PCT    = 23;
    localparam int LONG_SET    = 150;

    // one box transaction as offered on the input channel
    typedef struct packed {
        logic first;
        box_t box;
    } box_txn_t;

    // one result transaction as expected on the output channel
    typedef struct packed {
        logic                   keep;
        logic [IDX_W-1:0]       index;
        logic [COUNT_OUT_W-1:0] count;
        logic                   ovf;
    } verdict_t;

    // clock, reset and all block inputs start at known values
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [THR_W-1:0]        iou_threshold = THR_RESET;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    first_box = 1'b0;
    logic signed [BOX_W-1:0] box_left = '0;
    logic signed [BOX_W-1:0] box_top = '0;
    logic [SIZE_W-1:0]       box_width = '0;
    logic [SIZE_W-1:0]       box_height = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    keep;
    logic [IDX_W-1:0]        box_index;
    logic [COUNT_OUT_W-1:0]  kept_count;
    logic                    overflow;

    // stimulus and checking bookkeeping
    box_txn_t    pending_boxes[$];
    verdict_t    expected_verdicts[$];
    bit          in_fire = 1'b0;
    bit          idle_on = 1'b1;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          boxes_taken = 0;
    int          failures = 0;
    int          cycles = 0;

    // predictor state: kept store, set position and threshold
    box_t              kept_box[N_KEPT];
    logic [AREA_W-1:0] kept_area[N_KEPT];
    int unsigned       kept_n = 0;
    int unsigned       set_pos = 0;
    logic [THR_W-1:0]  thr_model = THR_RESET;

    greedy_box_suppression #(
        .MAX_KEPT(N_KEPT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .iou_threshold (iou_threshold),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .first_box     (first_box),
        .box_left      (box_left),
        .box_top       (box_top),
        .box_width     (box_width),
        .box_height    (box_height),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .keep          (keep),
        .box_index     (box_index),
        .kept_count    (kept_count),
        .overflow      (overflow)
    );

    always #5 clk = ~clk;

    // length of the overlap of two spans along one axis, full precision
    function automatic int unsigned span_overlap(input int a0, input int alen,
                                                 input int b0, input int blen);
        int lo;
        int hi;
        int ea;
        int eb;
        lo = (a0 > b0) ? a0 : b0;
        ea = a0 + alen;
        eb = b0 + blen;
        hi = (ea < eb) ? ea : eb;
        return (hi > lo) ? int'(hi - lo) : 0;
    endfunction

    // greedy suppression of one box against the kept store
    function automatic verdict_t suppress_box(input box_txn_t t);
        verdict_t    v;
        logic [63:0] area;
        logic [63:0] inter;
        logic [63:0] uni;
        logic        survive;
        int unsigned j;
        survive = 1'b1;
        if (t.first)
        begin
            kept_n  = 0;
            set_pos = 0;
        end
        area    = 64'(t.box.width) * 64'(t.box.height);
        v.index = set_pos[IDX_W-1:0];
        if (set_pos < POS_MAX)
            set_pos++;
        for (j = 0; j < kept_n; j++)
        begin
            inter = 64'(span_overlap(int'(t.box.left), int'(t.box.width),
                                     int'(kept_box[j].left), int'(kept_box[j].width)))
                  * 64'(span_overlap(int'(t.box.top), int'(t.box.height),
                                     int'(kept_box[j].top), int'(kept_box[j].height)));
            uni = area + 64'(kept_area[j]) - inter;
            // exact ratio test, no division
            if ((inter << 16) > 64'(thr_model) * uni)
                survive = 1'b0;
        end
        v.ovf = 1'b0;
        if (survive)
        begin
            if (kept_n < N_KEPT)
            begin
                kept_box[kept_n]  = t.box;
                kept_area[kept_n] = area[AREA_W-1:0];
                kept_n++;
            end
            else
                v.ovf = 1'b1;
        end
        v.keep  = survive;
        v.count = kept_n[COUNT_OUT_W-1:0];
        return v;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // monitor: input transactions feed the predictor, output transactions
    // are checked against the oldest expectation
    always @(posedge clk)
    begin : monitor
        box_txn_t seen;
        verdict_t want;
        in_fire = rst_n && in_valid && !in_stall;
        // threshold update lands when the write channel handshakes
        if (rst_n && cfg_valid && cfg_ready)
            thr_model = iou_threshold;
        if (in_fire)
        begin
            seen.first      = first_box;
            seen.box.left   = box_left;
            seen.box.top    = box_top;
            seen.box.width  = box_width;
            seen.box.height = box_height;
            expected_verdicts.insert(expected_verdicts.size(), suppress_box(seen));
            boxes_taken++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("result transaction with nothing expected");
                failures++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                check_field("keep", want.keep, keep);
                check_field("box_index", want.index, box_index);
                check_field("kept_count", want.count, kept_count);
                check_field("overflow", want.ovf, overflow);
            end
        end
    end

    // driver: a held payload only moves on after its transaction
    always @(negedge clk)
    begin : driver
        box_txn_t nxt;
        if (!in_valid || in_fire)
        begin
            if (pending_boxes.size() != 0 && !(idle_on && $urandom_range(99) < IDLE_PCT))
            begin
                nxt = pending_boxes.pop_front();
                in_valid   <= 1'b1;
                first_box  <= nxt.first;
                box_left   <= nxt.box.left;
                box_top    <= nxt.box.top;
                box_width  <= nxt.box.width;
                box_height <= nxt.box.height;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls plus one long hold-off so the block backs up
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && boxes_taken >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            out_stall <= 1'b1;
        end
        else
            out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic add_box(input logic first, input int l, input int t,
                           input int w, input int h);
        box_txn_t b;
        b.first      = first;
        b.box.left   = 16'(l);
        b.box.top    = 16'(t);
        b.box.width  = 15'(w);
        b.box.height = 15'(h);
        pending_boxes.insert(pending_boxes.size(), b);
    endtask

    // idle means nothing queued, nothing offered and nothing outstanding
    task automatic wait_drained();
        while (pending_boxes.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] val);
        @(negedge clk);
        cfg_valid     = 1'b1;
        iou_threshold = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // one box of a given flavor: disjoint grid, full-range noise or cluster
    task automatic gen_box(input logic first, input int mode, input int k,
                           input int cx, input int cy);
        int w;
        int h;
        case (mode)
            0: add_box(first, cx + (k % 8) * 200, cy + (k / 8) * 200,
                       64 + $urandom_range(100), 64 + $urandom_range(100));
            1: add_box(first, int'($urandom), int'($urandom),
                       $urandom_range(32767), $urandom_range(32767));
            default:
            begin
                // mostly overlapping boxes near the set center, some with no area
                w = ($urandom_range(15) == 0) ? 0 : 100 + $urandom_range(1400);
                h = ($urandom_range(15) == 0) ? 0 : 100 + $urandom_range(1400);
                add_box(first, cx + $urandom_range(600) - 300,
                        cy + $urandom_range(600) - 300, w, h);
            end
        endcase
    endtask

    // random sets: mostly well formed, with noise and stray set starts
    task automatic random_sets(input int total);
        int   made;
        int   len;
        int   mode;
        int   cx;
        int   cy;
        int   k;
        logic first;
        made = 0;
        while (made < total)
        begin
            mode = $urandom_range(9);
            if (mode > 2)
                mode = 2;
            len = (mode == 0) ? 66 + $urandom_range(4) : 1 + $urandom_range(24);
            cx  = $urandom_range(62000) - 32768;
            cy  = $urandom_range(62000) - 32768;
            for (k = 0; k < len && made < total; k++)
            begin
                // grid sets always start clean so the store fills and overflows
                if (k == 0)
                    first = (mode == 0) || ($urandom_range(19) != 0);
                else
                    first = ($urandom_range(49) == 0);
                gen_box(first, (mode != 1 && $urandom_range(9) == 0) ? 1 : mode, k, cx, cy);
                made++;
            end
        end
    endtask

    // stimulus sequence
    initial
    begin : stimulus
        int k;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at the reset threshold; the set begins at reset
        add_box(1'b0, 0, 0, 160, 160);
        add_box(1'b0, 0, 0, 160, 160);            // identical, suppressed
        add_box(1'b0, 320, 0, 160, 160);          // disjoint
        add_box(1'b0, 160, 0, 160, 160);          // touching on both sides
        add_box(1'b0, 0, 0, 0, 160);              // no area
        add_box(1'b0, 0, 0, 0, 160);              // union of zero with the last one
        add_box(1'b0, 80, 0, 160, 160);           // overlap below the limit
        add_box(1'b0, 40, 0, 160, 160);           // overlap above the limit
        add_box(1'b1, -32768, -32768, 32767, 32767);
        add_box(1'b0, 32767, 32767, 32767, 32767); // far edge past 16 bits
        add_box(1'b0, -32768, -32768, 32767, 32767);
        add_box(1'b0, -1, -1, 32767, 32767);
        add_box(1'b0, 0, 0, 32767, 32767);
        add_box(1'b1, 0, 0, 0, 0);
        add_box(1'b0, 0, 0, 0, 0);
        add_box(1'b1, 100, 100, 50, 50);
        add_box(1'b1, 100, 100, 50, 50);          // restart clears the store
        add_box(1'b0, 32767, -32768, 32767, 1);
        wait_drained();

        write_threshold(16'd0);
        random_sets(130);
        wait_drained();

        write_threshold(16'hFFFF);
        random_sets(100);
        wait_drained();

        // back-to-back stretch, no idling on either side
        write_threshold(16'd32768);
        idle_on = 1'b0;
        random_sets(130);
        wait_drained();
        idle_on = 1'b1;

        write_threshold(16'd1);
        random_sets(90);
        wait_drained();

        write_threshold(16'($urandom));
        random_sets(130);
        wait_drained();

        // one long set with no restart, mostly overlapping boxes
        write_threshold(16'd16384);
        add_box(1'b1, 0, 0, 300, 300);
        for (k = 0; k < LONG_SET; k++)
            gen_box(1'b0, ($urandom_range(3) == 0) ? 1 : 2, k, 0, 0);
        wait_drained();

        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
